>>> sv/tctp_pkg.sv
// Shared types, widths and constants of the hit-to-tube position mapper.
`default_nettype none
package tctp_pkg;

    // Field widths
    localparam int BOARD_W = 5;
    localparam int CHAN_W  = 5;
    localparam int ML_W    = 2;
    localparam int BASE_W  = 6;
    localparam int LAYER_W = 4;
    localparam int COL_W   = 9;
    localparam int POS_W   = 22;
    localparam int PITCH_W = 16;
    localparam int MLP_W   = 18;

    // APB register file
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Fixed chamber geometry
    localparam int NUM_CHANNELS          = 24;
    localparam int LAYERS_PER_MULTILAYER = 4;
    localparam int ML_SHIFT              = $clog2(LAYERS_PER_MULTILAYER);

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Register indexes
    localparam logic [2:0] REG_CHAMBER_KIND     = 3'd0;
    localparam logic [2:0] REG_FLIP_BOARDS      = 3'd1;
    localparam logic [2:0] REG_COLUMN_BY_TUBE   = 3'd2;
    localparam logic [2:0] REG_TRIGGER_BOARD    = 3'd3;
    localparam logic [2:0] REG_COLUMN_PITCH     = 3'd4;
    localparam logic [2:0] REG_LAYER_PITCH      = 3'd5;
    localparam logic [2:0] REG_TUBE_RADIUS      = 3'd6;
    localparam logic [2:0] REG_MULTILAYER_PITCH = 3'd7;

    // Reset values of the geometry registers
    localparam logic [PITCH_W-1:0] COLUMN_PITCH_RST     = 16'd3866;
    localparam logic [PITCH_W-1:0] LAYER_PITCH_RST      = 16'd3348;
    localparam logic [PITCH_W-1:0] TUBE_RADIUS_RST      = 16'd1920;
    localparam logic [MLP_W-1:0]   MULTILAYER_PITCH_RST = 18'd57403;

    typedef struct packed {
        logic               chamber_kind;
        logic               flip_boards;
        logic               column_by_tube;
        logic [BOARD_W-1:0] trigger_board;
        logic [PITCH_W-1:0] column_pitch;
        logic [PITCH_W-1:0] layer_pitch;
        logic [PITCH_W-1:0] tube_radius;
        logic [MLP_W-1:0]   multilayer_pitch;
    } t_cfg;

    typedef struct packed {
        logic               action;
        logic [BOARD_W-1:0] board;
        logic [CHAN_W-1:0]  channel;
        logic [ML_W-1:0]    entry_multilayer;
        logic [BASE_W-1:0]  entry_column;
        logic               entry_active;
    } t_req;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [COL_W-1:0]   column;
        logic               hit_valid;
    } t_tube;

endpackage
`default_nettype wire

>>> sv/tctp_cfg.sv
// APB register file holding the chamber geometry and mapping mode.
`default_nettype none
module tctp_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tctp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tctp_pkg::DATA_W-1:0]   pwdata,
    output logic      [tctp_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output tctp_pkg::t_cfg                     o_cfg
);
    import tctp_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_CHAMBER_KIND:     n_cfg.chamber_kind     = pwdata[0];
                REG_FLIP_BOARDS:      n_cfg.flip_boards      = pwdata[0];
                REG_COLUMN_BY_TUBE:   n_cfg.column_by_tube   = pwdata[0];
                REG_TRIGGER_BOARD:    n_cfg.trigger_board    = pwdata[BOARD_W-1:0];
                REG_COLUMN_PITCH:     n_cfg.column_pitch     = pwdata[PITCH_W-1:0];
                REG_LAYER_PITCH:      n_cfg.layer_pitch      = pwdata[PITCH_W-1:0];
                REG_TUBE_RADIUS:      n_cfg.tube_radius      = pwdata[PITCH_W-1:0];
                REG_MULTILAYER_PITCH: n_cfg.multilayer_pitch = pwdata[MLP_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chamber_kind     <= 1'b0;
            r_cfg.flip_boards      <= 1'b0;
            r_cfg.column_by_tube   <= 1'b0;
            r_cfg.trigger_board    <= '0;
            r_cfg.column_pitch     <= COLUMN_PITCH_RST;
            r_cfg.layer_pitch      <= LAYER_PITCH_RST;
            r_cfg.tube_radius      <= TUBE_RADIUS_RST;
            r_cfg.multilayer_pitch <= MULTILAYER_PITCH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back
    always_comb begin
        unique case (reg_idx)
            REG_CHAMBER_KIND:     prdata = DATA_W'(r_cfg.chamber_kind);
            REG_FLIP_BOARDS:      prdata = DATA_W'(r_cfg.flip_boards);
            REG_COLUMN_BY_TUBE:   prdata = DATA_W'(r_cfg.column_by_tube);
            REG_TRIGGER_BOARD:    prdata = DATA_W'(r_cfg.trigger_board);
            REG_COLUMN_PITCH:     prdata = DATA_W'(r_cfg.column_pitch);
            REG_LAYER_PITCH:      prdata = DATA_W'(r_cfg.layer_pitch);
            REG_TUBE_RADIUS:      prdata = DATA_W'(r_cfg.tube_radius);
            REG_MULTILAYER_PITCH: prdata = DATA_W'(r_cfg.multilayer_pitch);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> sv/tctp_map.sv
// Board table and channel-to-tube mapping stage.
`default_nettype none
module tctp_map #(
    parameter int NUM_BOARDS   = 32,
    parameter int TUBE_LAYERS  = 8,
    parameter int TUBE_COLUMNS = 54
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tctp_pkg::t_cfg i_cfg,
    input  wire logic           i_req_valid,
    input  wire tctp_pkg::t_req i_req,
    output logic                o_valid,
    output tctp_pkg::t_tube     o_tube
);
    import tctp_pkg::*;

    localparam int IDX_W = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;

    logic [ML_W-1:0]   r_ml     [NUM_BOARDS];
    logic [BASE_W-1:0] r_base   [NUM_BOARDS];
    logic              r_active [NUM_BOARDS];

    logic               board_ok;
    logic [IDX_W-1:0]   idx;
    logic               wr_en;
    logic [ML_W-1:0]    rd_ml;
    logic [BASE_W-1:0]  rd_base;
    logic               rd_active;
    logic [1:0]         lmap;
    logic [COL_W-1:0]   cmap;
    logic [COL_W-1:0]   base_col;
    t_tube              n_tube;
    logic               r_valid;
    t_tube              r_tube;

    assign board_ok = {1'b0, i_req.board} < (BOARD_W + 1)'(NUM_BOARDS);
    assign idx      = i_req.board[IDX_W-1:0];
    assign wr_en    = i_req_valid && !i_req.action && board_ok;

    // Board table, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BOARDS; b++) begin
                r_ml[b]     <= '0;
                r_base[b]   <= '0;
                r_active[b] <= 1'b0;
            end
        end else if (wr_en) begin
            r_ml[idx]     <= i_req.entry_multilayer;
            r_base[idx]   <= i_req.entry_column;
            r_active[idx] <= i_req.entry_active;
        end
    end

    // Entry read; boards beyond the table read as empty
    assign rd_ml     = board_ok ? r_ml[idx]     : '0;
    assign rd_base   = board_ok ? r_base[idx]   : '0;
    assign rd_active = board_ok ? r_active[idx] : 1'b0;

    // Channel pattern
    always_comb begin
        if (i_cfg.flip_boards) begin
            lmap = i_cfg.chamber_kind ? (i_req.channel[1:0] + 2'd2) : ~i_req.channel[1:0];
            cmap = COL_W'(i_req.channel[CHAN_W-1:2]);
        end else begin
            lmap = i_cfg.chamber_kind ? (i_req.channel[1:0] ^ 2'b01) : i_req.channel[1:0];
            cmap = COL_W'(5) - COL_W'(i_req.channel[CHAN_W-1:2]);
        end
    end

    // Base column, as tube number or in units of six
    assign base_col = i_cfg.column_by_tube ? COL_W'(rd_base)
                    : (COL_W'(rd_base) << 2) + (COL_W'(rd_base) << 1);

    always_comb begin
        n_tube.layer     = {rd_ml, lmap};
        n_tube.column    = base_col + cmap;
        n_tube.hit_valid = board_ok && (i_req.board != i_cfg.trigger_board) && rd_active
                        && (i_req.channel < CHAN_W'(NUM_CHANNELS))
                        && ({1'b0, n_tube.layer} < (LAYER_W + 1)'(TUBE_LAYERS))
                        && ({1'b0, n_tube.column} < (COL_W + 1)'(TUBE_COLUMNS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req_valid && i_req.action;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tube <= n_tube;
    end

    assign o_valid = r_valid;
    assign o_tube  = r_tube;

    // A load lands in the table by the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_active[$past(idx)] == $past(i_req.entry_active))
               && (r_base[$past(idx)] == $past(i_req.entry_column)))
        else $error("board table entry not updated by load");

endmodule
`default_nettype wire

>>> sv/tctp_pos.sv
// Tube centre position: product stage, then sum and saturation into the result register.
`default_nettype none
module tctp_pos (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tctp_pkg::t_cfg                  i_cfg,
    input  wire logic                            i_valid,
    input  wire tctp_pkg::t_tube                 i_tube,
    output logic                                 o_strobe,
    output logic      [tctp_pkg::LAYER_W-1:0]    o_tube_layer,
    output logic      [tctp_pkg::COL_W-1:0]      o_tube_column,
    output logic                                 o_hit_valid,
    output logic      [tctp_pkg::POS_W-1:0]      o_x_pos,
    output logic      [tctp_pkg::POS_W-1:0]      o_y_pos
);
    import tctp_pkg::*;

    localparam int Q_W     = LAYER_W - ML_SHIFT;
    localparam int CPROD_W = COL_W + PITCH_W;
    localparam int LPROD_W = LAYER_W + PITCH_W;
    localparam int MPROD_W = MLP_W + Q_W;
    localparam int QPROD_W = PITCH_W + Q_W;
    localparam int XSUM_W  = CPROD_W + 1;
    localparam int YS_W    = POS_W + 2;

    logic [Q_W-1:0]     q;
    logic               r_a_valid;
    t_tube              r_a_tube;
    logic               r_a_parity;
    logic [CPROD_W-1:0] r_col_prod;
    logic [LPROD_W-1:0] r_lay_prod;
    logic [MPROD_W-1:0] r_mlp_prod;
    logic [QPROD_W-1:0] r_lpq_prod;

    logic [XSUM_W-1:0]     x_sum;
    logic [POS_W-1:0]      y_pos_part;
    logic signed [YS_W-1:0] y_sum;
    logic [POS_W-1:0]      n_x;
    logic [POS_W-1:0]      n_y;

    logic               r_strobe;
    t_tube              r_out_tube;
    logic [POS_W-1:0]   r_x;
    logic [POS_W-1:0]   r_y;

    // Multilayer index of the layer
    assign q = i_tube.layer[LAYER_W-1:ML_SHIFT];

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_tube   <= i_tube;
        r_a_parity <= i_tube.layer[0] ^ ~i_cfg.chamber_kind;
        r_col_prod <= CPROD_W'(i_tube.column) * CPROD_W'(i_cfg.column_pitch);
        r_lay_prod <= LPROD_W'(i_tube.layer) * LPROD_W'(i_cfg.layer_pitch);
        r_mlp_prod <= MPROD_W'(i_cfg.multilayer_pitch) * MPROD_W'(q);
        r_lpq_prod <= QPROD_W'(i_cfg.layer_pitch) * QPROD_W'(q);
    end

    // Sums; x is never negative, y stays below the top of range
    assign x_sum = XSUM_W'(i_cfg.tube_radius) + XSUM_W'(r_col_prod)
                 + (r_a_parity ? XSUM_W'(i_cfg.column_pitch[PITCH_W-1:1]) : '0);
    assign y_pos_part = POS_W'(i_cfg.tube_radius) + POS_W'(r_lay_prod) + POS_W'(r_mlp_prod);
    assign y_sum = $signed(YS_W'(y_pos_part)) - $signed(YS_W'({r_lpq_prod, 2'b00}));

    always_comb begin
        if (!r_a_tube.hit_valid) begin
            n_x = '0;
            n_y = '0;
        end else begin
            n_x = (x_sum > XSUM_W'(POS_MAX)) ? POS_MAX : x_sum[POS_W-1:0];
            n_y = y_sum[YS_W-1] ? '0 : y_sum[POS_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_tube <= r_a_tube;
        r_x        <= n_x;
        r_y        <= n_y;
    end

    assign o_strobe      = r_strobe;
    assign o_tube_layer  = r_out_tube.layer;
    assign o_tube_column = r_out_tube.column;
    assign o_hit_valid   = r_out_tube.hit_valid;
    assign o_x_pos       = r_x;
    assign o_y_pos       = r_y;

endmodule
`default_nettype wire

>>> sv/tdc_channel_to_tube_position.sv
// Top level of the hit-to-tube position mapper.
// Takes one request per clock: busy is held low, so a request is accepted on
// every cycle with start high. A hit request gives its result on the o_ ports,
// marked by o_strobe for one cycle; a load request writes the board table and
// gives no result. There are four register stages: input capture, table read
// and channel mapping, the position products, and the sum with saturation. The
// board table sits in flip-flops cleared at reset, so no clearing pass follows
// reset. Results come in request order and cannot be held off by the receiver.
`default_nettype none
module tdc_channel_to_tube_position #(
    parameter int NUM_BOARDS   = 32,
    parameter int TUBE_LAYERS  = 8,
    parameter int TUBE_COLUMNS = 54
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_action,
    input  wire logic [tctp_pkg::BOARD_W-1:0]  i_board,
    input  wire logic [tctp_pkg::CHAN_W-1:0]   i_channel,
    input  wire logic [tctp_pkg::ML_W-1:0]     i_entry_multilayer,
    input  wire logic [tctp_pkg::BASE_W-1:0]   i_entry_column,
    input  wire logic                          i_entry_active,
    // result channel
    output logic                               o_strobe,
    output logic      [tctp_pkg::LAYER_W-1:0]  o_tube_layer,
    output logic      [tctp_pkg::COL_W-1:0]    o_tube_column,
    output logic                               o_hit_valid,
    output logic      [tctp_pkg::POS_W-1:0]    o_x_pos,
    output logic      [tctp_pkg::POS_W-1:0]    o_y_pos,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tctp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tctp_pkg::DATA_W-1:0]   pwdata,
    output logic      [tctp_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import tctp_pkg::*;

    t_cfg   cfg;
    logic   r_req_valid;
    t_req   r_req;
    logic   map_valid;
    t_tube  map_tube;

    assign busy = 1'b0;

    tctp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req.action           <= i_action;
        r_req.board            <= i_board;
        r_req.channel          <= i_channel;
        r_req.entry_multilayer <= i_entry_multilayer;
        r_req.entry_column     <= i_entry_column;
        r_req.entry_active     <= i_entry_active;
    end

    tctp_map #(
        .NUM_BOARDS   (NUM_BOARDS),
        .TUBE_LAYERS  (TUBE_LAYERS),
        .TUBE_COLUMNS (TUBE_COLUMNS)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (r_req_valid),
        .i_req       (r_req),
        .o_valid     (map_valid),
        .o_tube      (map_tube)
    );

    tctp_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (map_valid),
        .i_tube        (map_tube),
        .o_strobe      (o_strobe),
        .o_tube_layer  (o_tube_layer),
        .o_tube_column (o_tube_column),
        .o_hit_valid   (o_hit_valid),
        .o_x_pos       (o_x_pos),
        .o_y_pos       (o_y_pos)
    );

    // Every result traces back to an accepted hit request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_action, 4))
        else $error("result without a matching hit request");

    // A load request never produces a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_action) |-> ##4 !o_strobe)
        else $error("load request produced a result");

    // A valid hit lies inside the chamber bounds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_hit_valid) |->
            ({1'b0, o_tube_layer} < (LAYER_W + 1)'(TUBE_LAYERS))
            && ({1'b0, o_tube_column} < (COL_W + 1)'(TUBE_COLUMNS)))
        else $error("valid hit outside chamber bounds");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the hit-to-tube position mapper: directed table, then random phases.
module tb_top;
    import tctp_pkg::*;

    localparam int N_BOARDS      = 32;
    localparam int N_LAYERS      = 8;
    localparam int N_COLUMNS     = 54;
    localparam int SETTLE_CYCLES = 8;     // pipeline is four deep
    localparam int STALL_LIMIT   = 500;
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [COL_W-1:0]   column;
        logic               valid;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } t_tube_pos;

    typedef struct packed {
        t_req      req;
        logic      fixed;    // expected position typed in by hand
        t_tube_pos pos;
    } t_stim_row;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // Request side
    logic                start              = 1'b0;
    logic                busy;
    logic                i_action           = 1'b0;
    logic [BOARD_W-1:0]  i_board            = '0;
    logic [CHAN_W-1:0]   i_channel          = '0;
    logic [ML_W-1:0]     i_entry_multilayer = '0;
    logic [BASE_W-1:0]   i_entry_column     = '0;
    logic                i_entry_active     = 1'b0;

    // Result side
    logic                o_strobe;
    logic [LAYER_W-1:0]  o_tube_layer;
    logic [COL_W-1:0]    o_tube_column;
    logic                o_hit_valid;
    logic [POS_W-1:0]    o_x_pos;
    logic [POS_W-1:0]    o_y_pos;

    // Register port
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    tdc_channel_to_tube_position #(
        .NUM_BOARDS   (N_BOARDS),
        .TUBE_LAYERS  (N_LAYERS),
        .TUBE_COLUMNS (N_COLUMNS)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_board            (i_board),
        .i_channel          (i_channel),
        .i_entry_multilayer (i_entry_multilayer),
        .i_entry_column     (i_entry_column),
        .i_entry_active     (i_entry_active),
        .o_strobe           (o_strobe),
        .o_tube_layer       (o_tube_layer),
        .o_tube_column      (o_tube_column),
        .o_hit_valid        (o_hit_valid),
        .o_x_pos            (o_x_pos),
        .o_y_pos            (o_y_pos),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // Bench copy of the configuration and the board table
    t_cfg              geom;
    logic [ML_W-1:0]   board_ml  [N_BOARDS];
    logic [BASE_W-1:0] board_col [N_BOARDS];
    logic              board_on  [N_BOARDS];

    t_tube_pos pending_pos[$];
    t_stim_row directed[$];
    int        n_fail = 0;
    int        stall  = 0;

    // Tube position of a hit request, from the bench copy of the state
    function automatic t_tube_pos locate_tube(t_req r);
        logic [LAYER_W-1:0] lmap;
        logic [LAYER_W-1:0] lay;
        logic [COL_W-1:0]   cmap;
        logic [COL_W-1:0]   col;
        logic               par;
        longint             xs;
        longint             ys;
        t_tube_pos          res;
        if (geom.flip_boards) begin
            if (geom.chamber_kind)
                lmap = LAYER_W'((r.channel + 2) % 4);
            else
                lmap = LAYER_W'(3 - r.channel % 4);
            cmap = COL_W'(r.channel / 4);
        end else begin
            if (geom.chamber_kind)
                lmap = r.channel[0] ? LAYER_W'(r.channel[1:0]) - 4'd1
                                    : LAYER_W'(r.channel[1:0]) + 4'd1;
            else
                lmap = LAYER_W'(r.channel[1:0]);
            cmap = 9'd5 - COL_W'(r.channel / 4);
        end
        lay = {board_ml[r.board], 2'b00} + lmap;
        col = (geom.column_by_tube ? COL_W'(board_col[r.board])
                                   : COL_W'(board_col[r.board]) * 9'd6) + cmap;
        res.layer  = lay;
        res.column = col;
        res.valid  = (r.board != geom.trigger_board) && board_on[r.board]
                     && (r.channel < NUM_CHANNELS) && (lay < N_LAYERS)
                     && (col < N_COLUMNS);
        res.x = '0;
        res.y = '0;
        if (res.valid) begin
            // even layers sit half a pitch over on type C, odd ones on type A
            par = geom.chamber_kind ? lay[0] : ~lay[0];
            xs = longint'(geom.tube_radius) + longint'(col) * longint'(geom.column_pitch)
                 + (par ? longint'(geom.column_pitch >> 1) : 64'sd0);
            ys = longint'(geom.tube_radius) + longint'(lay) * longint'(geom.layer_pitch)
                 + (longint'(geom.multilayer_pitch) - 4 * longint'(geom.layer_pitch))
                   * longint'(lay >> 2);
            res.x = (xs < 0) ? '0 : (xs > longint'(POS_MAX)) ? POS_MAX : POS_W'(xs);
            res.y = (ys < 0) ? '0 : (ys > longint'(POS_MAX)) ? POS_MAX : POS_W'(ys);
        end
        return res;
    endfunction

    function automatic t_stim_row load_row(int brd, int ml, int col, bit en);
        t_stim_row r;
        r = '0;
        r.req.action           = 1'b0;
        r.req.board            = BOARD_W'(brd);
        r.req.entry_multilayer = ML_W'(ml);
        r.req.entry_column     = BASE_W'(col);
        r.req.entry_active     = en;
        return r;
    endfunction

    function automatic t_stim_row hit_row(int brd, int ch, bit fixed, int lay, int col,
                                          bit v, int x, int y);
        t_stim_row r;
        r = '0;
        r.req.action   = 1'b1;
        r.req.board    = BOARD_W'(brd);
        r.req.channel  = CHAN_W'(ch);
        r.fixed        = fixed;
        r.pos.layer    = LAYER_W'(lay);
        r.pos.column   = COL_W'(col);
        r.pos.valid    = v;
        r.pos.x        = POS_W'(x);
        r.pos.y        = POS_W'(y);
        return r;
    endfunction

    // Append a row to the directed table
    function automatic void add_row(t_stim_row r);
        directed.insert(directed.size(), r);
    endfunction

    // Geometry register value for a phase: random, all ones, or zero
    function automatic logic [31:0] geom_value(int gsel);
        return (gsel == 0) ? 32'($urandom()) : (gsel == 1) ? 32'hFFFF_FFFF : 32'd0;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            n_fail++;
        end
    endtask

    // Issue one request and wait for it to be taken
    task automatic send(t_stim_row r);
        start              <= 1'b1;
        i_action           <= r.req.action;
        i_board            <= r.req.board;
        i_channel          <= r.req.channel;
        i_entry_multilayer <= r.req.entry_multilayer;
        i_entry_column     <= r.req.entry_column;
        i_entry_active     <= r.req.entry_active;
        do @(posedge i_clk); while (busy);
        if (r.req.action) begin
            pending_pos.insert(pending_pos.size(), r.fixed ? r.pos : locate_tube(r.req));
        end else begin
            board_ml[r.req.board]  = r.req.entry_multilayer;
            board_col[r.req.board] = r.req.entry_column;
            board_on[r.req.board]  = r.req.entry_active;
        end
    endtask

    // Random burst of idle cycles on the request side
    task automatic gap(bit calm);
        if (!calm && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Let the pipeline run dry before touching the registers
    task automatic settle();
        start <= 1'b0;
        while (pending_pos.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read back
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        logic [31:0] kept;
        case (idx)
            REG_CHAMBER_KIND:     begin geom.chamber_kind     = val[0];       kept = 32'(val[0]); end
            REG_FLIP_BOARDS:      begin geom.flip_boards      = val[0];       kept = 32'(val[0]); end
            REG_COLUMN_BY_TUBE:   begin geom.column_by_tube   = val[0];       kept = 32'(val[0]); end
            REG_TRIGGER_BOARD:    begin geom.trigger_board    = val[4:0];     kept = 32'(val[4:0]); end
            REG_COLUMN_PITCH:     begin geom.column_pitch     = val[15:0];    kept = 32'(val[15:0]); end
            REG_LAYER_PITCH:      begin geom.layer_pitch      = val[15:0];    kept = 32'(val[15:0]); end
            REG_TUBE_RADIUS:      begin geom.tube_radius      = val[15:0];    kept = 32'(val[15:0]); end
            default:              begin geom.multilayer_pitch = val[17:0];    kept = 32'(val[17:0]); end
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", kept, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        t_tube_pos want;
        if (o_strobe === 1'b1) begin
            if (pending_pos.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual layer %0d column %0d",
                         $time, o_tube_layer, o_tube_column);
                n_fail++;
            end else begin
                want = pending_pos.pop_front();
                check_field("tube_layer", 32'(want.layer), 32'(o_tube_layer));
                check_field("tube_column", 32'(want.column), 32'(o_tube_column));
                check_field("hit_valid", 32'(want.valid), 32'(o_hit_valid));
                check_field("x_pos", 32'(want.x), 32'(o_x_pos));
                check_field("y_pos", 32'(want.y), 32'(o_y_pos));
            end
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1 || (psel && penable && pready))
            stall <= 0;
        else
            stall <= stall + 1;
        if (stall >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_stim_row r;
        bit        calm;
        int        gsel;
        geom.chamber_kind     = 1'b0;
        geom.flip_boards      = 1'b0;
        geom.column_by_tube   = 1'b0;
        geom.trigger_board    = '0;
        geom.column_pitch     = COLUMN_PITCH_RST;
        geom.layer_pitch      = LAYER_PITCH_RST;
        geom.tube_radius      = TUBE_RADIUS_RST;
        geom.multilayer_pitch = MULTILAYER_PITCH_RST;
        for (int b = 0; b < N_BOARDS; b++) begin
            board_ml[b]  = '0;
            board_col[b] = '0;
            board_on[b]  = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset geometry, type C unflipped, columns scaled by six
        add_row(hit_row(0, 0, 1, 0, 5, 0, 0, 0));        // empty table after reset
        add_row(hit_row(5, 23, 1, 3, 0, 0, 0, 0));       // inactive board
        add_row(load_row(5, 0, 0, 1));
        add_row(hit_row(5, 0, 1, 0, 5, 1, 23183, 1920));
        add_row(hit_row(5, 23, 1, 3, 0, 1, 1920, 11964));
        add_row(hit_row(5, 31, 1, 3, 510, 0, 0, 0));     // channel past the board
        add_row(hit_row(5, 24, 1, 0, 511, 0, 0, 0));
        add_row(load_row(31, 3, 63, 1));                 // largest entry
        add_row(hit_row(31, 0, 1, 12, 383, 0, 0, 0));
        add_row(load_row(1, 1, 8, 1));
        add_row(hit_row(1, 0, 0, 0, 0, 0, 0, 0));
        add_row(hit_row(1, 3, 0, 0, 0, 0, 0, 0));
        add_row(hit_row(1, 4, 0, 0, 0, 0, 0, 0));
        add_row(load_row(1, 1, 9, 1));                   // column bound
        add_row(hit_row(1, 23, 1, 7, 54, 0, 0, 0));
        add_row(load_row(2, 2, 0, 1));                   // layer bound
        add_row(hit_row(2, 1, 1, 9, 5, 0, 0, 0));
        add_row(load_row(3, 0, 2, 0));
        add_row(hit_row(3, 5, 1, 1, 16, 0, 0, 0));
        add_row(load_row(0, 0, 1, 1));                   // trigger board, active
        add_row(hit_row(0, 2, 1, 2, 11, 0, 0, 0));
        add_row(hit_row(1, 20, 0, 0, 0, 0, 0, 0));
        foreach (directed[i]) begin
            send(directed[i]);
            gap(1'b0);
        end

        // Random phases over chamber type, flip, column mode and geometry extremes
        for (int k = 0; k < N_PHASES; k++) begin
            settle();
            calm = (k == N_PHASES - 1);
            gsel = k % 3;
            write_reg(REG_CHAMBER_KIND, 32'(k[0]));
            write_reg(REG_FLIP_BOARDS, 32'(k[1]));
            write_reg(REG_COLUMN_BY_TUBE, 32'(k[2]));
            write_reg(REG_TRIGGER_BOARD, (gsel == 1) ? 32'd31 :
                      (gsel == 2) ? 32'd0 : 32'($urandom_range(0, 31)));
            write_reg(REG_COLUMN_PITCH, geom_value(gsel));
            write_reg(REG_LAYER_PITCH, geom_value(gsel));
            write_reg(REG_TUBE_RADIUS, geom_value(gsel));
            write_reg(REG_MULTILAYER_PITCH, geom_value(gsel));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = '0;
                r.req.board            = BOARD_W'($urandom_range(0, N_BOARDS - 1));
                r.req.channel          = ($urandom_range(0, 9) == 0)
                                         ? CHAN_W'($urandom_range(24, 31))
                                         : CHAN_W'($urandom_range(0, 23));
                r.req.entry_active     = ($urandom_range(0, 7) != 0);
                r.req.entry_multilayer = ($urandom_range(0, 7) == 0)
                                         ? ML_W'($urandom_range(2, 3))
                                         : ML_W'($urandom_range(0, 1));
                // mostly keep base columns inside the chamber for the current mode
                if (geom.column_by_tube)
                    r.req.entry_column = ($urandom_range(0, 9) == 0)
                                         ? BASE_W'($urandom_range(54, 63))
                                         : BASE_W'($urandom_range(0, 53));
                else
                    r.req.entry_column = ($urandom_range(0, 9) == 0)
                                         ? BASE_W'($urandom_range(9, 63))
                                         : BASE_W'($urandom_range(0, 8));
                r.req.action = ($urandom_range(0, 3) != 0);
                send(r);
                gap(calm);
            end
        end

        settle();
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
